>>> hw/rtl/swd_seq_pkg.sv
// ----------------------------------------------------------------------------
// SWD sequencer package
// Shared types and constants of the SWD debug transfer sequencer.
// ----------------------------------------------------------------------------
package swd_seq_pkg;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_REQ      = 4'd1,
    PH_BLK_CMD  = 4'd2,
    PH_BLK_DATA = 4'd3,
    PH_W_FLUSH  = 4'd4,
    PH_W_MPOST  = 4'd5,
    PH_W_MREAD  = 4'd6,
    PH_W_APPOST = 4'd7,
    PH_W_DPREAD = 4'd8,
    PH_W_WRITE  = 4'd9,
    PH_W_FINAL  = 4'd10,
    PH_W_BPOST  = 4'd11,
    PH_W_BREAD  = 4'd12,
    PH_W_BWRITE = 4'd13
  } phase_t;

  typedef enum logic [1:0] {
    PA_NONE  = 2'd0,
    PA_READ  = 2'd1,
    PA_WRITE = 2'd2
  } pend_t;

  localparam logic [1:0] CMD_START    = 2'd0;
  localparam logic [1:0] CMD_REQUEST  = 2'd1;
  localparam logic [1:0] CMD_COMPLETE = 2'd2;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  localparam logic [1:0] KIND_ISSUE = 2'd0;
  localparam logic [1:0] KIND_WORD  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam int RQ_AP    = 0;
  localparam int RQ_READ  = 1;
  localparam int RQ_MATCH = 4;
  localparam int RQ_MASK  = 5;
  localparam logic [7:0] RDBUFF   = 8'h0E;
  localparam logic [2:0] ACK_OK   = 3'd1;
  localparam logic [4:0] MISMATCH = 5'h10;

  // Decoded input item, as classified by the front end.
  typedef struct packed {
    logic [1:0]  cmd;
    logic        block_mode;
    logic [15:0] count;
    logic [7:0]  request_byte;
    logic [31:0] request_word;
    logic [2:0]  swd_ack;
    logic [31:0] swd_rdata;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  swd_request;
    logic [31:0] swd_wdata;
    logic        keep_data;
    logic [31:0] word;
    logic [15:0] done_count;
    logic [4:0]  done_ack;
    logic        last;
  } res_t;

endpackage

>>> hw/rtl/swd_seq_front.sv
// ----------------------------------------------------------------------------
// SWD sequencer front end
// Accepts items, drops item kinds that mean nothing, and queues the rest.
// ----------------------------------------------------------------------------
module swd_seq_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  swd_seq_pkg::item_t   in_item,
  output logic                 q_valid,
  output swd_seq_pkg::item_t   q_item,
  input  logic                 q_take
);
  import swd_seq_pkg::*;

  // Two-entry queue.
  item_t       mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        do_push;
  logic        do_pop;

  assign full    = (fill == 2'd2);
  // Item kind 3 is accepted but never queued.
  assign do_push = push && !full && (in_item.cmd != CMD_UNUSED);
  assign do_pop  = q_take && q_valid;
  assign q_valid = (fill != 2'd0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> hw/rtl/swd_seq_back.sv
// ----------------------------------------------------------------------------
// SWD sequencer back end
// Carries out one queued item a cycle unless earlier results still wait to be taken; an item yields up to two results.
// ----------------------------------------------------------------------------
module swd_seq_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          match_retry_limit,
  input  logic                 q_valid,
  input  swd_seq_pkg::item_t   q_item,
  output logic                 q_take,
  output logic                 res_valid,
  output swd_seq_pkg::res_t    res_item,
  input  logic                 res_take
);
  import swd_seq_pkg::*;

  phase_t      phase, phase_next;
  pend_t       pend, pend_next;
  logic        is_block, is_block_next;
  logic [15:0] items_left, items_left_next;
  logic [15:0] done_total, done_total_next;
  logic        posted_read, posted_read_next;
  logic        write_unchecked, write_unchecked_next;
  logic [7:0]  cur_rq, cur_rq_next;
  logic [31:0] cmp_val, cmp_val_next;
  logic [31:0] cmp_mask, cmp_mask_next;
  logic [15:0] retries, retries_next;

  // Result buffer: room for three results, though one item yields at most two.
  res_t        rb [3];
  res_t        rb_next [3];
  logic [1:0]  rb_cnt, rb_cnt_next;
  logic [1:0]  rb_idx;
  logic [1:0]  n;
  logic        busy;

  assign busy      = (rb_cnt != 2'd0);
  assign q_take    = q_valid && (!busy || (rb_cnt == 2'd1 && rb_idx == 2'd0 && res_take)
                     || (rb_idx == rb_cnt - 2'd1 && res_take));
  assign res_valid = busy;
  assign res_item  = rb[rb_idx];

  function automatic res_t mk(input logic [1:0] k, input logic [7:0] rq,
                              input logic [31:0] wd, input logic kp,
                              input logic [31:0] w, input logic [15:0] dc,
                              input logic [4:0] da);
    res_t r;
    r.kind = k; r.swd_request = rq; r.swd_wdata = wd; r.keep_data = kp;
    r.word = w; r.done_count = dc; r.done_ack = da; r.last = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic ok;
    logic [15:0] il;
    logic [7:0] brq;
    phase_next = phase; pend_next = pend; is_block_next = is_block;
    items_left_next = items_left; done_total_next = done_total;
    posted_read_next = posted_read; write_unchecked_next = write_unchecked;
    cur_rq_next = cur_rq; cmp_val_next = cmp_val; cmp_mask_next = cmp_mask;
    retries_next = retries;
    for (int i = 0; i < 3; i++) rb_next[i] = '0;
    n = 2'd0;
    ok = (q_item.swd_ack == ACK_OK);
    il = 16'd0;
    brq = 8'd0;
    if (q_take) begin
      case (q_item.cmd)
        CMD_START: begin
          is_block_next = q_item.block_mode;
          il = q_item.block_mode ? q_item.count : {8'd0, q_item.count[7:0]};
          items_left_next = il;
          done_total_next = 16'd0; posted_read_next = 1'b0;
          write_unchecked_next = 1'b0; retries_next = 16'd0; pend_next = PA_NONE;
          if (il == 16'd0) begin
            rb_next[0] = mk(KIND_DONE, 8'd0, 32'd0, 1'b0, 32'd0, 16'd0, 5'd0);
            n = 2'd1; phase_next = PH_IDLE;
          end else begin
            phase_next = q_item.block_mode ? PH_BLK_CMD : PH_REQ;
          end
        end
        CMD_REQUEST: begin
          case (phase)
            PH_REQ: begin
              cur_rq_next = q_item.request_byte;
              cmp_val_next = q_item.request_word;
              if (q_item.request_byte[RQ_READ]) begin
                write_unchecked_next = 1'b0;
                if (posted_read) begin
                  if (q_item.request_byte[RQ_AP] && !q_item.request_byte[RQ_MATCH]) begin
                    pend_next = PA_NONE;
                    rb_next[0] = mk(KIND_ISSUE, {4'd0, q_item.request_byte[3:0]},
                                    32'd0, 1'b1, 32'd0, 16'd0, 5'd0);
                  end else begin
                    pend_next = PA_READ;
                    rb_next[0] = mk(KIND_ISSUE, RDBUFF, 32'd0, 1'b1, 32'd0, 16'd0, 5'd0);
                  end
                  n = 2'd1; phase_next = PH_W_FLUSH;
                end else begin
                  rb_next[0] = mk(KIND_ISSUE, {4'd0, q_item.request_byte[3:0]}, 32'd0,
                                  !q_item.request_byte[RQ_MATCH]
                                  && !q_item.request_byte[RQ_AP],
                                  32'd0, 16'd0, 5'd0);
                  n = 2'd1;
                  if (q_item.request_byte[RQ_MATCH]) begin
                    retries_next = match_retry_limit;
                    phase_next = q_item.request_byte[RQ_AP] ? PH_W_MPOST : PH_W_MREAD;
                  end else begin
                    phase_next = q_item.request_byte[RQ_AP] ? PH_W_APPOST : PH_W_DPREAD;
                  end
                end
              end else if (posted_read) begin
                pend_next = PA_WRITE;
                rb_next[0] = mk(KIND_ISSUE, RDBUFF, 32'd0, 1'b1, 32'd0, 16'd0, 5'd0);
                n = 2'd1; phase_next = PH_W_FLUSH;
              end else if (q_item.request_byte[RQ_MASK]) begin
                cmp_mask_next = q_item.request_word;
                done_total_next = done_total + 16'd1;
                items_left_next = items_left - 16'd1;
                if (items_left == 16'd1) begin
                  if (write_unchecked) begin
                    rb_next[0] = mk(KIND_ISSUE, RDBUFF, 32'd0, 1'b0, 32'd0, 16'd0, 5'd0);
                    phase_next = PH_W_FINAL;
                  end else begin
                    rb_next[0] = mk(KIND_DONE, 8'd0, 32'd0, 1'b0, 32'd0,
                                    done_total + 16'd1, {2'd0, ACK_OK});
                    phase_next = PH_IDLE; pend_next = PA_NONE;
                  end
                  n = 2'd1;
                end else begin
                  phase_next = PH_REQ;
                end
              end else begin
                write_unchecked_next = 1'b1;
                rb_next[0] = mk(KIND_ISSUE, {4'd0, q_item.request_byte[3:0]},
                                q_item.request_word, 1'b0, 32'd0, 16'd0, 5'd0);
                n = 2'd1; phase_next = PH_W_WRITE;
              end
            end
            PH_BLK_CMD: begin
              cur_rq_next = q_item.request_byte;
              if (q_item.request_byte[RQ_READ]) begin
                if (q_item.request_byte[RQ_AP]) begin
                  rb_next[0] = mk(KIND_ISSUE, {4'd0, q_item.request_byte[3:0]}, 32'd0,
                                  1'b0, 32'd0, 16'd0, 5'd0);
                  phase_next = PH_W_BPOST;
                end else begin
                  rb_next[0] = mk(KIND_ISSUE, {4'd0, q_item.request_byte[3:0]}, 32'd0,
                                  1'b1, 32'd0, 16'd0, 5'd0);
                  phase_next = PH_W_BREAD;
                end
              end else begin
                rb_next[0] = mk(KIND_ISSUE, {4'd0, q_item.request_byte[3:0]},
                                q_item.request_word, 1'b0, 32'd0, 16'd0, 5'd0);
                phase_next = PH_W_BWRITE;
              end
              n = 2'd1;
            end
            PH_BLK_DATA: begin
              rb_next[0] = mk(KIND_ISSUE, {4'd0, cur_rq[3:0]}, q_item.request_word,
                              1'b0, 32'd0, 16'd0, 5'd0);
              n = 2'd1; phase_next = PH_W_BWRITE;
            end
            default: ;
          endcase
        end
        CMD_COMPLETE: begin
          // Helper value used by the AP block read completion phase.
          brq = (cur_rq[RQ_AP] && items_left == 16'd1) ? RDBUFF : {4'd0, cur_rq[3:0]};
          case (phase)
            PH_W_FLUSH: begin
              if (!ok) begin
                rb_next[0] = mk(KIND_DONE, 8'd0, 32'd0, 1'b0, 32'd0, done_total,
                                {2'd0, q_item.swd_ack});
                n = 2'd1; phase_next = PH_IDLE; pend_next = PA_NONE;
              end else begin
                rb_next[0] = mk(KIND_WORD, 8'd0, 32'd0, 1'b0, q_item.swd_rdata,
                                16'd0, 5'd0);
                n = 2'd2;
                pend_next = PA_NONE;
                if (pend == PA_NONE) begin
                  // The new AP read is now posted; count the transfer.
                  done_total_next = done_total + 16'd1;
                  items_left_next = items_left - 16'd1;
                  if (items_left == 16'd1) begin
                    rb_next[1] = mk(KIND_ISSUE, RDBUFF, 32'd0, 1'b1, 32'd0, 16'd0, 5'd0);
                    phase_next = PH_W_FINAL;
                  end else begin
                    n = 2'd1; phase_next = PH_REQ;
                  end
                end else if (pend == PA_READ) begin
                  posted_read_next = 1'b0;
                  rb_next[1] = mk(KIND_ISSUE, {4'd0, cur_rq[3:0]}, 32'd0,
                                  !cur_rq[RQ_MATCH] && !cur_rq[RQ_AP],
                                  32'd0, 16'd0, 5'd0);
                  if (cur_rq[RQ_MATCH]) begin
                    retries_next = match_retry_limit;
                    phase_next = cur_rq[RQ_AP] ? PH_W_MPOST : PH_W_MREAD;
                  end else begin
                    phase_next = cur_rq[RQ_AP] ? PH_W_APPOST : PH_W_DPREAD;
                  end
                end else begin
                  posted_read_next = 1'b0;
                  if (cur_rq[RQ_MASK]) begin
                    cmp_mask_next = cmp_val;
                    done_total_next = done_total + 16'd1;
                    items_left_next = items_left - 16'd1;
                    if (items_left == 16'd1) begin
                      // write_unchecked is clear after a flush.
                      rb_next[1] = mk(KIND_DONE, 8'd0, 32'd0, 1'b0, 32'd0,
                                      done_total + 16'd1, {2'd0, ACK_OK});
                      phase_next = PH_IDLE;
                    end else begin
                      n = 2'd1; phase_next = PH_REQ;
                    end
                  end else begin
                    write_unchecked_next = 1'b1;
                    rb_next[1] = mk(KIND_ISSUE, {4'd0, cur_rq[3:0]}, cmp_val, 1'b0,
                                    32'd0, 16'd0, 5'd0);
                    phase_next = PH_W_WRITE;
                  end
                end
              end
            end
            PH_W_MPOST: begin
              if (!ok) begin
                rb_next[0] = mk(KIND_DONE, 8'd0, 32'd0, 1'b0, 32'd0, done_total,
                                {2'd0, q_item.swd_ack});
                phase_next = PH_IDLE; pend_next = PA_NONE;
              end else begin
                rb_next[0] = mk(KIND_ISSUE, {4'd0, cur_rq[3:0]}, 32'd0, 1'b0, 32'd0,
                                16'd0, 5'd0);
                phase_next = PH_W_MREAD;
              end
              n = 2'd1;
            end
            PH_W_MREAD: begin
              n = 2'd1;
              if (ok && ((q_item.swd_rdata & cmp_mask) == cmp_val)) begin
                done_total_next = done_total + 16'd1;
                items_left_next = items_left - 16'd1;
                if (items_left == 16'd1) begin
                  if (posted_read || write_unchecked) begin
                    rb_next[0] = mk(KIND_ISSUE, RDBUFF, 32'd0, posted_read, 32'd0,
                                    16'd0, 5'd0);
                    phase_next = PH_W_FINAL;
                  end else begin
                    rb_next[0] = mk(KIND_DONE, 8'd0, 32'd0, 1'b0, 32'd0,
                                    done_total + 16'd1, {2'd0, ACK_OK});
                    phase_next = PH_IDLE; pend_next = PA_NONE;
                  end
                end else begin
                  n = 2'd0; phase_next = PH_REQ;
                end
              end else if (retries != 16'd0) begin
                retries_next = retries - 16'd1;
                rb_next[0] = mk(KIND_ISSUE, {4'd0, cur_rq[3:0]}, 32'd0, 1'b0, 32'd0,
                                16'd0, 5'd0);
              end else begin
                rb_next[0] = mk(KIND_DONE, 8'd0, 32'd0, 1'b0, 32'd0, done_total,
                                {2'd0, q_item.swd_ack} | MISMATCH);
                phase_next = PH_IDLE; pend_next = PA_NONE;
              end
            end
            PH_W_APPOST, PH_W_DPREAD, PH_W_WRITE: begin
              if (!ok) begin
                rb_next[0] = mk(KIND_DONE, 8'd0, 32'd0, 1'b0, 32'd0, done_total,
                                {2'd0, q_item.swd_ack});
                n = 2'd1; phase_next = PH_IDLE; pend_next = PA_NONE;
              end else begin
                if (phase == PH_W_DPREAD) begin
                  rb_next[0] = mk(KIND_WORD, 8'd0, 32'd0, 1'b0, q_item.swd_rdata,
                                  16'd0, 5'd0);
                  n = 2'd1;
                end
                if (phase == PH_W_APPOST) posted_read_next = 1'b1;
                done_total_next = done_total + 16'd1;
                items_left_next = items_left - 16'd1;
                if (items_left == 16'd1) begin
                  if (posted_read_next || write_unchecked) begin
                    rb_next[n] = mk(KIND_ISSUE, RDBUFF, 32'd0, posted_read_next, 32'd0,
                                    16'd0, 5'd0);
                    phase_next = PH_W_FINAL;
                  end else begin
                    rb_next[n] = mk(KIND_DONE, 8'd0, 32'd0, 1'b0, 32'd0,
                                    done_total + 16'd1, {2'd0, ACK_OK});
                    phase_next = PH_IDLE; pend_next = PA_NONE;
                  end
                  n = n + 2'd1;
                end else begin
                  phase_next = PH_REQ;
                end
              end
            end
            PH_W_FINAL: begin
              if (ok && posted_read) begin
                rb_next[0] = mk(KIND_WORD, 8'd0, 32'd0, 1'b0, q_item.swd_rdata,
                                16'd0, 5'd0);
                n = 2'd1;
              end
              posted_read_next = 1'b0;
              rb_next[n] = mk(KIND_DONE, 8'd0, 32'd0, 1'b0, 32'd0, done_total,
                              {2'd0, q_item.swd_ack});
              n = n + 2'd1;
              phase_next = PH_IDLE; pend_next = PA_NONE;
            end
            PH_W_BPOST: begin
              if (!ok) begin
                rb_next[0] = mk(KIND_DONE, 8'd0, 32'd0, 1'b0, 32'd0, done_total,
                                {2'd0, q_item.swd_ack});
                phase_next = PH_IDLE; pend_next = PA_NONE;
              end else begin
                rb_next[0] = mk(KIND_ISSUE, brq, 32'd0, 1'b1, 32'd0, 16'd0, 5'd0);
                phase_next = PH_W_BREAD;
              end
              n = 2'd1;
            end
            PH_W_BREAD: begin
              if (!ok) begin
                rb_next[0] = mk(KIND_DONE, 8'd0, 32'd0, 1'b0, 32'd0, done_total,
                                {2'd0, q_item.swd_ack});
                n = 2'd1; phase_next = PH_IDLE; pend_next = PA_NONE;
              end else begin
                rb_next[0] = mk(KIND_WORD, 8'd0, 32'd0, 1'b0, q_item.swd_rdata,
                                16'd0, 5'd0);
                done_total_next = done_total + 16'd1;
                items_left_next = items_left - 16'd1;
                if (items_left == 16'd1) begin
                  rb_next[1] = mk(KIND_DONE, 8'd0, 32'd0, 1'b0, 32'd0,
                                  done_total + 16'd1, {2'd0, ACK_OK});
                  phase_next = PH_IDLE; pend_next = PA_NONE;
                end else begin
                  // The next read uses the count left after this one.
                  rb_next[1] = mk(KIND_ISSUE,
                                  (cur_rq[RQ_AP] && items_left == 16'd2) ? RDBUFF
                                  : {4'd0, cur_rq[3:0]},
                                  32'd0, 1'b1, 32'd0, 16'd0, 5'd0);
                end
                n = 2'd2;
              end
            end
            PH_W_BWRITE: begin
              if (!ok) begin
                rb_next[0] = mk(KIND_DONE, 8'd0, 32'd0, 1'b0, 32'd0, done_total,
                                {2'd0, q_item.swd_ack});
                n = 2'd1; phase_next = PH_IDLE; pend_next = PA_NONE;
              end else begin
                done_total_next = done_total + 16'd1;
                items_left_next = items_left - 16'd1;
                if (items_left == 16'd1) begin
                  posted_read_next = 1'b0;
                  rb_next[0] = mk(KIND_ISSUE, RDBUFF, 32'd0, 1'b0, 32'd0, 16'd0, 5'd0);
                  n = 2'd1; phase_next = PH_W_FINAL;
                end else begin
                  phase_next = PH_BLK_DATA;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      if (n != 2'd0) rb_next[n - 2'd1].last = 1'b1;
    end
    rb_cnt_next = q_take ? n : ((res_take && busy && rb_idx == rb_cnt - 2'd1) ? 2'd0
                               : rb_cnt);
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      for (int i = 0; i < 3; i++) rb[i] <= rb_next[i];
      cur_rq   <= cur_rq_next;
      cmp_val  <= cmp_val_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; pend <= PA_NONE; is_block <= 1'b0;
      items_left <= '0; done_total <= '0; posted_read <= 1'b0;
      write_unchecked <= 1'b0; cmp_mask <= '1; retries <= '0;
      rb_cnt <= '0; rb_idx <= '0;
    end else begin
      phase <= phase_next; pend <= pend_next; is_block <= is_block_next;
      items_left <= items_left_next; done_total <= done_total_next;
      posted_read <= posted_read_next; write_unchecked <= write_unchecked_next;
      cmp_mask <= cmp_mask_next; retries <= retries_next;
      rb_cnt <= rb_cnt_next;
      if (q_take) rb_idx <= 2'd0;
      else if (res_take && busy) rb_idx <= rb_idx + 2'd1;
    end
  end

endmodule

>>> hw/rtl/swd_debug_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// SWD debug transfer sequencer
// Turns debug-probe transfer packets into SWD transactions and responses.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake     Contents
// input     in         push / full   cmd, block_mode, count, request, ack, data
// result    out        pop / empty   kind, swd_request, swd_wdata, keep_data,
//                                    word, done_count, done_ack, last
// config    in         cfg_we        match_retry_limit
//
// One item is taken per cycle when results are drained as fast; an item yields
// up to two results, and the back end takes no new item until the last result
// of its item is being taken. A two-entry queue between front and back end
// absorbs stalls. Reset is synchronous and clears all control state; the match
// mask comes out of reset as all ones.
module swd_debug_transfer_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic        block_mode,
  input  logic [15:0] count,
  input  logic [7:0]  request_byte,
  input  logic [31:0] request_word,
  input  logic [2:0]  swd_ack,
  input  logic [31:0] swd_rdata,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  swd_request,
  output logic [31:0] swd_wdata,
  output logic        keep_data,
  output logic [31:0] word,
  output logic [15:0] done_count,
  output logic [4:0]  done_ack,
  output logic        last
);
  import swd_seq_pkg::*;

  logic [15:0] match_retry_limit;
  item_t       in_item;
  item_t       q_item;
  logic        q_valid;
  logic        q_take;
  logic        res_valid;
  res_t        res_item;

  // Users write the retry limit register only while the block is idle (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      match_retry_limit <= 16'd0;
    end else if (cfg_we) begin
      match_retry_limit <= cfg_wdata;
    end
  end

  assign in_item = '{cmd: cmd, block_mode: block_mode, count: count,
                     request_byte: request_byte, request_word: request_word,
                     swd_ack: swd_ack, swd_rdata: swd_rdata};

  swd_seq_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
  );

  swd_seq_back u_back (
    .clk(clk), .rst(rst), .match_retry_limit(match_retry_limit),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
    .res_valid(res_valid), .res_item(res_item), .res_take(pop)
  );

  assign empty       = !res_valid;
  assign kind        = res_item.kind;
  assign swd_request = res_item.swd_request;
  assign swd_wdata   = res_item.swd_wdata;
  assign keep_data   = res_item.keep_data;
  assign word        = res_item.word;
  assign done_count  = res_item.done_count;
  assign done_ack    = res_item.done_ack;
  assign last        = res_item.last;

  // A result never shows an item kind outside the defined three.
  a_kind_valid: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (kind == KIND_ISSUE || kind == KIND_WORD || kind == KIND_DONE))
    else $error("invalid result kind");

  // A stalled result stays present and holds its kind and last flag until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(last)))
    else $error("result changed while stalled");

endmodule

>>> tb/sv/tb_swd_debug_transfer_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SWD debug transfer sequencer testbench
// Drives transfer packets, requests and SWD completions into the sequencer,
// predicts every result with a behavioural copy of the sequencer and checks
// each popped result field by field, under several idling patterns.
// ----------------------------------------------------------------------------
module tb_swd_debug_transfer_sequencer;
  import swd_seq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        push;
  logic        full;
  logic [1:0]  cmd;
  logic        block_mode;
  logic [15:0] count;
  logic [7:0]  request_byte;
  logic [31:0] request_word;
  logic [2:0]  swd_ack;
  logic [31:0] swd_rdata;
  logic        empty;
  logic        pop;
  logic [1:0]  kind;
  logic [7:0]  swd_request;
  logic [31:0] swd_wdata;
  logic        keep_data;
  logic [31:0] word;
  logic [15:0] done_count;
  logic [4:0]  done_ack;
  logic        last;

  swd_debug_transfer_sequencer u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .cmd(cmd), .block_mode(block_mode), .count(count),
    .request_byte(request_byte), .request_word(request_word), .swd_ack(swd_ack),
    .swd_rdata(swd_rdata), .empty(empty), .pop(pop), .kind(kind),
    .swd_request(swd_request), .swd_wdata(swd_wdata), .keep_data(keep_data),
    .word(word), .done_count(done_count), .done_ack(done_ack), .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Test controls shared between the stimulus, the result checker and the watchdog.
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int quiet_cycles;
  int failures;
  int items_sent;

  // Expected results, oldest first.
  res_t expected_results[$];

  // --------------------------------------------------------------------------
  // Behavioural copy of the sequencer. It is stepped once for every transfer
  // that the sequencer accepts, and appends the results that it should produce.
  // --------------------------------------------------------------------------
  phase_t      seq_phase;
  bit          seq_block;
  bit [15:0]   seq_left;
  bit [15:0]   seq_done;
  bit          seq_posted;
  bit          seq_write_open;
  bit [7:0]    seq_req;
  bit [31:0]   seq_value;
  bit [31:0]   seq_mask;
  bit [15:0]   seq_retries;
  pend_t       seq_pending;
  bit [15:0]   retry_limit;
  int          new_results;

  function automatic void add_result(logic [1:0] k, logic [7:0] rq, logic [31:0] wd,
                                     logic keep, logic [31:0] w, logic [15:0] dc,
                                     logic [4:0] da);
    res_t r;
    r = '0;
    r.kind = k; r.swd_request = rq; r.swd_wdata = wd; r.keep_data = keep;
    r.word = w; r.done_count = dc; r.done_ack = da;
    expected_results.push_back(r);
    new_results++;
  endfunction

  // Only the low four request bits go out on the wire.
  function automatic void issue_txn(logic [7:0] rq, logic [31:0] wd, logic keep,
                                    phase_t nxt);
    add_result(KIND_ISSUE, rq & 8'h0F, wd, keep, '0, '0, '0);
    seq_phase = nxt;
  endfunction

  function automatic void finish_packet(logic [4:0] ack);
    add_result(KIND_DONE, '0, '0, 1'b0, '0, seq_done, ack);
    seq_phase = PH_IDLE;
    seq_pending = PA_NONE;
  endfunction

  // A packet of single transfers ends by draining a posted read, by confirming the
  // final write through a read of the read buffer, or else with a done result.
  function automatic void close_singles();
    if (seq_posted) issue_txn(RDBUFF, '0, 1'b1, PH_W_FINAL);
    else if (seq_write_open) issue_txn(RDBUFF, '0, 1'b0, PH_W_FINAL);
    else finish_packet({2'b00, ACK_OK});
  endfunction

  function automatic void count_transfer();
    seq_done++;
    seq_left--;
    if (seq_left == 0) close_singles();
    else seq_phase = PH_REQ;
  endfunction

  function automatic void start_read();
    if (seq_req[RQ_MATCH]) begin
      seq_retries = retry_limit;
      if (seq_req[RQ_AP]) issue_txn(seq_req, '0, 1'b0, PH_W_MPOST);
      else issue_txn(seq_req, '0, 1'b0, PH_W_MREAD);
    end else if (seq_req[RQ_AP]) begin
      issue_txn(seq_req, '0, 1'b0, PH_W_APPOST);
    end else begin
      issue_txn(seq_req, '0, 1'b1, PH_W_DPREAD);
    end
  endfunction

  function automatic void start_write();
    if (seq_req[RQ_MASK]) begin
      seq_mask = seq_value;
      count_transfer();
    end else begin
      seq_write_open = 1'b1;
      issue_txn(seq_req, seq_value, 1'b0, PH_W_WRITE);
    end
  endfunction

  // In an AP block read the last word is fetched from the read buffer.
  function automatic void next_block_read();
    if (seq_req[RQ_AP] && seq_left == 1) issue_txn(RDBUFF, '0, 1'b1, PH_W_BREAD);
    else issue_txn(seq_req, '0, 1'b1, PH_W_BREAD);
  endfunction

  function automatic void take_request(logic [7:0] rb, logic [31:0] w);
    if (seq_phase == PH_REQ) begin
      seq_req = rb;
      seq_value = w;
      if (rb[RQ_READ]) begin
        seq_write_open = 1'b0;
        if (seq_posted) begin
          if (rb[RQ_AP] && !rb[RQ_MATCH]) begin
            seq_pending = PA_NONE;
            issue_txn(rb, '0, 1'b1, PH_W_FLUSH);
          end else begin
            seq_pending = PA_READ;
            issue_txn(RDBUFF, '0, 1'b1, PH_W_FLUSH);
          end
        end else begin
          start_read();
        end
      end else if (seq_posted) begin
        seq_pending = PA_WRITE;
        issue_txn(RDBUFF, '0, 1'b1, PH_W_FLUSH);
      end else begin
        start_write();
      end
    end else if (seq_phase == PH_BLK_CMD) begin
      seq_req = rb;
      if (rb[RQ_READ]) begin
        if (rb[RQ_AP]) issue_txn(rb, '0, 1'b0, PH_W_BPOST);
        else next_block_read();
      end else begin
        issue_txn(rb, w, 1'b0, PH_W_BWRITE);
      end
    end else if (seq_phase == PH_BLK_DATA) begin
      issue_txn(seq_req, w, 1'b0, PH_W_BWRITE);
    end
  endfunction

  function automatic void take_completion(logic [2:0] ack, logic [31:0] rd);
    bit ok;
    ok = (ack == ACK_OK);
    case (seq_phase)
      PH_W_FLUSH: begin
        if (!ok) finish_packet({2'b00, ack});
        else begin
          add_result(KIND_WORD, '0, '0, 1'b0, rd, '0, '0);
          if (seq_pending == PA_NONE) count_transfer();
          else begin
            seq_posted = 1'b0;
            if (seq_pending == PA_READ) begin
              seq_pending = PA_NONE;
              start_read();
            end else begin
              seq_pending = PA_NONE;
              start_write();
            end
          end
        end
      end
      PH_W_MPOST: begin
        if (!ok) finish_packet({2'b00, ack});
        else issue_txn(seq_req, '0, 1'b0, PH_W_MREAD);
      end
      PH_W_MREAD: begin
        if (ok && (rd & seq_mask) == seq_value) count_transfer();
        else if (seq_retries > 0) begin
          seq_retries--;
          issue_txn(seq_req, '0, 1'b0, PH_W_MREAD);
        end else finish_packet({2'b00, ack} | MISMATCH);
      end
      PH_W_APPOST: begin
        if (!ok) finish_packet({2'b00, ack});
        else begin
          seq_posted = 1'b1;
          count_transfer();
        end
      end
      PH_W_DPREAD: begin
        if (!ok) finish_packet({2'b00, ack});
        else begin
          add_result(KIND_WORD, '0, '0, 1'b0, rd, '0, '0);
          count_transfer();
        end
      end
      PH_W_WRITE: begin
        if (!ok) finish_packet({2'b00, ack});
        else count_transfer();
      end
      PH_W_FINAL: begin
        if (ok && seq_posted) add_result(KIND_WORD, '0, '0, 1'b0, rd, '0, '0);
        seq_posted = 1'b0;
        finish_packet({2'b00, ack});
      end
      PH_W_BPOST: begin
        if (!ok) finish_packet({2'b00, ack});
        else next_block_read();
      end
      PH_W_BREAD: begin
        if (!ok) finish_packet({2'b00, ack});
        else begin
          add_result(KIND_WORD, '0, '0, 1'b0, rd, '0, '0);
          seq_done++;
          seq_left--;
          if (seq_left == 0) finish_packet({2'b00, ACK_OK});
          else next_block_read();
        end
      end
      PH_W_BWRITE: begin
        if (!ok) finish_packet({2'b00, ack});
        else begin
          seq_done++;
          seq_left--;
          if (seq_left == 0) begin
            seq_posted = 1'b0;
            issue_txn(RDBUFF, '0, 1'b0, PH_W_FINAL);
          end else seq_phase = PH_BLK_DATA;
        end
      end
      default: ;
    endcase
  endfunction

  // One accepted transfer: works out its results and marks the last of them.
  function automatic void predict_item(item_t it);
    new_results = 0;
    case (it.cmd)
      CMD_START: begin
        // A start always opens a fresh packet; the match mask survives it.
        seq_block = it.block_mode;
        seq_left = it.block_mode ? it.count : {8'h00, it.count[7:0]};
        seq_done = '0;
        seq_posted = 1'b0;
        seq_write_open = 1'b0;
        seq_retries = '0;
        seq_pending = PA_NONE;
        if (seq_left == 0) finish_packet('0);
        else seq_phase = seq_block ? PH_BLK_CMD : PH_REQ;
      end
      CMD_REQUEST: take_request(it.request_byte, it.request_word);
      CMD_COMPLETE: if (seq_phase >= PH_W_FLUSH) take_completion(it.swd_ack, it.swd_rdata);
      default: ;
    endcase
    if (new_results > 0) expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side. Inputs change only on the rising edge; full is sampled on the
  // falling edge, when it is stable, to decide whether the coming edge accepts.
  // --------------------------------------------------------------------------
  task automatic send_item(logic [1:0] c, logic bm, logic [15:0] cnt, logic [7:0] rb,
                           logic [31:0] rw, logic [2:0] ack, logic [31:0] rd);
    item_t it;
    it = '{cmd: c, block_mode: bm, count: cnt, request_byte: rb, request_word: rw,
           swd_ack: ack, swd_rdata: rd};
    push <= 1'b1;
    cmd <= c; block_mode <= bm; count <= cnt; request_byte <= rb;
    request_word <= rw; swd_ack <= ack; swd_rdata <= rd;
    do @(negedge clk); while (full);
    @(posedge clk);
    quiet_cycles = 0;
    predict_item(it);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  task automatic send_start(logic bm, logic [15:0] cnt);
    send_item(CMD_START, bm, cnt, 8'($urandom), $urandom, 3'($urandom), $urandom);
  endtask

  task automatic send_request(logic [7:0] rb, logic [31:0] w);
    send_item(CMD_REQUEST, 1'($urandom), 16'($urandom), rb, w, 3'($urandom), $urandom);
  endtask

  task automatic send_completion(logic [2:0] ack, logic [31:0] rd);
    send_item(CMD_COMPLETE, 1'($urandom), 16'($urandom), 8'($urandom), $urandom, ack, rd);
  endtask

  // Answers every SWD transaction the sequencer is waiting on with an OK ack.
  task automatic answer_ok();
    while (seq_phase >= PH_W_FLUSH) send_completion(ACK_OK, $urandom);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // The register is only written while the sequencer is idle. Ignored items
  // may still sit in the queue after the last result, so the write waits on after the drain.
  task automatic write_retry_limit(logic [15:0] v);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    retry_limit = v;
  endtask

  // --------------------------------------------------------------------------
  // Result checker.
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got);
    if (exp_v !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got);
      failures++;
    end
  endfunction

  initial begin
    res_t got;
    res_t exp_r;
    bit   taken;
    pop <= 1'b0;
    forever begin
      @(negedge clk);
      taken = pop && !empty;
      got = '{kind: kind, swd_request: swd_request, swd_wdata: swd_wdata,
              keep_data: keep_data, word: word, done_count: done_count,
              done_ack: done_ack, last: last};
      @(posedge clk);
      if (taken && !rst) begin
        quiet_cycles = 0;
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: kind %0d", got.kind);
          failures++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("kind", exp_r.kind, got.kind);
          check_field("swd_request", exp_r.swd_request, got.swd_request);
          check_field("swd_wdata", exp_r.swd_wdata, got.swd_wdata);
          check_field("keep_data", exp_r.keep_data, got.keep_data);
          check_field("word", exp_r.word, got.word);
          check_field("done_count", exp_r.done_count, got.done_count);
          check_field("done_ack", exp_r.done_ack, got.done_ack);
          check_field("last", exp_r.last, got.last);
        end
      end
      // A long hold-off lets the sequencer fill up and push back on its input.
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Ends the run if neither side moves a transfer for too long.
  always @(posedge clk) begin
    quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Empty packets, truncated single counts and items nobody is waiting for.
  task automatic test_empty_and_ignored();
    send_start(1'b0, 16'd0);
    send_start(1'b1, 16'd0);
    send_start(1'b0, 16'h0100);
    send_item(CMD_UNUSED, 1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
    send_completion(ACK_OK, 32'h1234_5678);
    send_request(8'h02, 32'h0);
  endtask

  // Writes, DP reads, posted AP reads and their flushes in one packet.
  task automatic test_single_transfers();
    send_start(1'b0, 16'd5);
    send_request(8'h04, 32'hFFFF_FFFF); answer_ok();
    send_request(8'h03, 32'h0);         answer_ok();
    send_request(8'h07, 32'h0);         answer_ok();
    send_request(8'h06, 32'h0);         answer_ok();
    send_request(8'h01, 32'hA5A5_5A5A); answer_ok();
  endtask

  // Mask write, a match read that matches on its retry if one is allowed, then one that never matches.
  task automatic test_match_reads();
    send_start(1'b0, 16'd3);
    send_request(8'h20, 32'h0000_00FF);
    send_request(8'h13, 32'h0000_0042);
    send_completion(ACK_OK, 32'hFFFF_FF00);
    send_completion(ACK_OK, 32'h1234_5642);
    send_request(8'h12, 32'h0000_0011);
    while (seq_phase >= PH_W_FLUSH) send_completion(ACK_OK, 32'h0);
    // Restore the all-ones mask for the following tests.
    send_start(1'b0, 16'd1);
    send_request(8'h20, 32'hFFFF_FFFF);
  endtask

  // Failing acks end the packet, including on a failed read.
  task automatic test_bad_ack();
    send_start(1'b0, 16'd2);
    send_request(8'h02, 32'h0);
    send_completion(3'd4, 32'hDEAD_BEEF);
    send_start(1'b1, 16'd2);
    send_request(8'h0F, 32'h0);
    send_completion(3'd2, 32'h0);
  endtask

  // Block reads through AP and DP, a block write, and a restart mid-packet.
  task automatic test_block_transfers();
    send_start(1'b1, 16'd3);
    send_request(8'h0F, 32'h0); answer_ok();
    send_start(1'b1, 16'd2);
    send_request(8'h00, 32'h0000_0001); answer_ok();
    send_request(8'hC0, 32'h8000_0000); answer_ok();
    send_start(1'b1, 16'hFFFF);
    send_request(8'h0A, 32'h0);
    send_completion(ACK_OK, $urandom);
    send_start(1'b0, 16'hFFFF);
    send_request(8'h00, 32'h0); answer_ok();
  endtask

  // One random, mostly well-formed packet with occasional noise.
  task automatic random_packet();
    logic [31:0] rd;
    logic [2:0]  ack;
    int          steps;
    send_start(1'($urandom_range(1)),
               ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 6)));
    steps = 0;
    while (seq_phase != PH_IDLE && steps < 40) begin
      steps++;
      if ($urandom_range(29) == 0) begin
        case ($urandom_range(2))
          0: send_item(CMD_UNUSED, 1'($urandom), 16'($urandom), 8'($urandom), $urandom,
                       3'($urandom), $urandom);
          1: send_start(1'($urandom_range(1)), 16'($urandom_range(0, 4)));
          default: if (seq_phase >= PH_W_FLUSH) send_request(8'($urandom), $urandom);
                   else send_completion(3'($urandom), $urandom);
        endcase
      end else if (seq_phase < PH_W_FLUSH) begin
        send_request(8'($urandom), $urandom);
      end else begin
        ack = ($urandom_range(11) == 0) ? 3'($urandom) : ACK_OK;
        rd = $urandom;
        if (seq_phase == PH_W_MREAD && $urandom_range(1))
          rd = seq_value | (rd & ~seq_mask);
        send_completion(ack, rd);
      end
      // Now and then the host waits for every response before going on.
      if ($urandom_range(39) == 0) wait_drained();
    end
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int n_items);
    int goal;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    goal = items_sent + n_items;
    while (items_sent < goal) random_packet();
  endtask

  // Results are held back while the host keeps sending, so the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 120;
    send_start(1'b1, 16'd12);
    send_request(8'h02, 32'h0);
    answer_ok();
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    push = 1'b0;
    cmd = CMD_START; block_mode = 1'b0; count = '0; request_byte = '0;
    request_word = '0; swd_ack = '0; swd_rdata = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
    quiet_cycles = 0; failures = 0; items_sent = 0;
    seq_phase = PH_IDLE; seq_block = 0; seq_left = 0; seq_done = 0;
    seq_posted = 0; seq_write_open = 0; seq_req = 0; seq_value = 0;
    seq_mask = 32'hFFFF_FFFF; seq_retries = 0; seq_pending = PA_NONE;
    retry_limit = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_ignored();
    test_single_transfers();
    test_match_reads();
    test_bad_ack();
    test_block_transfers();
    test_backpressure();

    write_retry_limit(16'd3);
    test_match_reads();
    test_random_phase(0, 0, 20);
    write_retry_limit(16'hFFFF);
    test_random_phase(72, 0, 20);
    write_retry_limit(16'd0);
    test_random_phase(0, 72, 20);
    write_retry_limit(16'd1);
    test_random_phase(36, 36, 20);

    wait_drained();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
